[rtl/core/sdq_pkg.sv]
`timescale 1ns / 1ps
// Package for the session dispatch queue.
// Holds command, status and register codes, cell control structs and default sizes.
package sdq_pkg;

	localparam int QUEUE_DEPTH_D     = 32;
	localparam int ACTIVE_DEPTH_D    = 16;
	localparam int SESSION_ID_BITS_D = 8;

	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [2:0] {
		CMD_ENQUEUE = 3'd0,
		CMD_FINISH  = 3'd1,
		CMD_TICK    = 3'd2,
		CMD_REMOVE  = 3'd3,
		CMD_COUNT   = 3'd4
	} command_t;

	typedef enum logic [2:0] {
		STS_OK         = 3'd0,
		STS_DUPLICATE  = 3'd1,
		STS_FULL       = 3'd2,
		STS_NOT_ACTIVE = 3'd3,
		STS_NOT_FOUND  = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_SLOTS  = 1'b0,
		REG_EXTRA_SLOTS = 1'b1
	} reg_index_t;

	// queue cell controls
	typedef struct packed {
		logic wr;   // write the new entry at the tail
		logic rm;   // drop the entry that matches the key
	} q_ctrl_t;

	// active slot cell controls
	typedef struct packed {
		logic clr;    // free the slot that matches the key
		logic alloc;  // take the first free slot
	} a_ctrl_t;

endpackage

[rtl/core/sdq_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the session dispatch queue.
// Depends on nothing.
interface sdq_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [7:0]  session_id;
	logic [31:0] peer_id;

	modport source (output valid, command, session_id, peer_id, input ready);
	modport sink (input valid, command, session_id, peer_id, output ready);
endinterface

interface sdq_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        granted_valid;
	logic [7:0]  granted_session;
	logic [5:0]  peer_count;
	logic [4:0]  active_count;
	logic [5:0]  queued_count;
	logic        last;

	modport source (output valid, status, granted_valid, granted_session, peer_count,
		active_count, queued_count, last, input ready);
	modport sink (input valid, status, granted_valid, granted_session, peer_count,
		active_count, queued_count, last, output ready);
endinterface

[rtl/core/sdq_qcell.sv]
`timescale 1ns / 1ps
// One wait queue cell: holds one entry, shifts from its upper neighbor on a drop.
// Depends on sdq_pkg.
module sdq_qcell #(
	parameter int IDX = 0,
	parameter int QW  = 6,
	parameter int SB  = 8,
	parameter int AW  = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sdq_pkg::q_ctrl_t  ctrl,
	input  logic [QW-1:0]     len,
	input  logic [SB-1:0]     key_sid,
	input  logic [31:0]       key_peer,
	input  logic [SB-1:0]     nxt_sid,
	input  logic [31:0]       nxt_peer,
	input  logic              drop_in,
	output logic              drop_out,
	input  logic [AW-1:0]     acc_in,
	output logic [AW-1:0]     acc_out,
	output logic [SB-1:0]     sid,
	output logic [31:0]       peer,
	output logic              match
);
	import sdq_pkg::*;

	logic [SB-1:0] sid_q;
	logic [31:0]   peer_q;
	logic [AW-1:0] acc_q;
	logic          valid;

	assign valid    = QW'(IDX) < len;
	assign match    = valid && (sid_q == key_sid);
	assign drop_out = drop_in || (ctrl.rm && match);
	assign sid      = sid_q;
	assign peer     = peer_q;
	assign acc_out  = acc_q;

	// entry storage: shift down on a drop, load at the tail on a write
	always_ff @(posedge clk) begin
		if (drop_out) begin
			sid_q  <= nxt_sid;
			peer_q <= nxt_peer;
		end else if (ctrl.wr && (len == QW'(IDX))) begin
			sid_q  <= key_sid;
			peer_q <= key_peer;
		end
	end

	// running peer match count, one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else begin
			acc_q <= acc_in + AW'(valid && (peer_q == key_peer));
		end
	end

endmodule

[rtl/core/sdq_acell.sv]
`timescale 1ns / 1ps
// One active slot cell: used flag, session and peer, first-free chain.
// Depends on sdq_pkg.
module sdq_acell #(
	parameter int SB = 8,
	parameter int AW = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sdq_pkg::a_ctrl_t  ctrl,
	input  logic [SB-1:0]     key_sid,
	input  logic [31:0]       key_peer,
	input  logic [SB-1:0]     new_sid,
	input  logic [31:0]       new_peer,
	input  logic              free_in,
	output logic              free_out,
	input  logic [AW-1:0]     acc_in,
	output logic [AW-1:0]     acc_out,
	output logic              match
);
	import sdq_pkg::*;

	logic          used_q;
	logic [SB-1:0] sid_q;
	logic [31:0]   peer_q;
	logic [AW-1:0] acc_q;
	logic          take;

	assign match    = used_q && (sid_q == key_sid);
	assign take     = ctrl.alloc && !used_q && !free_in;
	assign free_out = free_in || !used_q;
	assign acc_out  = acc_q;

	// slot occupancy and running peer count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			acc_q  <= '0;
		end else begin
			if (take) begin
				used_q <= 1'b1;
			end else if (ctrl.clr && match) begin
				used_q <= 1'b0;
			end
			acc_q <= acc_in + AW'(used_q && (peer_q == key_peer));
		end
	end

	// slot contents
	always_ff @(posedge clk) begin
		if (take) begin
			sid_q  <= new_sid;
			peer_q <= new_peer;
		end
	end

endmodule

[rtl/core/session_dispatch_queue_top.sv]
`timescale 1ns / 1ps
// Session dispatch queue: FIFO wait queue and active slots built as cell chains.
// Enqueue, finish, remove: result registered from S_EXEC once the output is free. Count:
// waits in S_COUNT while the peer count ripples through the cells, then reports from S_EXEC.
// Tick: grants are registered from S_GRANT, one per cycle while the output is free.
// One command at a time. Reset clears the queue length and all slot used flags; base 4, extra 0.
module session_dispatch_queue_top #(
	parameter int QUEUE_DEPTH     = sdq_pkg::QUEUE_DEPTH_D,
	parameter int ACTIVE_DEPTH    = sdq_pkg::ACTIVE_DEPTH_D,
	parameter int SESSION_ID_BITS = sdq_pkg::SESSION_ID_BITS_D
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [sdq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sdq_pkg::CFG_W-1:0]   cfg_data,
	sdq_req_if.sink                     req,
	sdq_rsp_if.source                   rsp
);
	import sdq_pkg::*;

	localparam int SB    = SESSION_ID_BITS;
	localparam int QW    = $clog2(QUEUE_DEPTH + 1);
	localparam int CW    = $clog2(ACTIVE_DEPTH + 1);
	localparam int LW    = (CW > 6) ? CW : 6;
	localparam int CMAX  = (QUEUE_DEPTH > ACTIVE_DEPTH) ? QUEUE_DEPTH : ACTIVE_DEPTH;
	localparam int NW    = $clog2(CMAX + 2);
	localparam int PW    = $clog2(QUEUE_DEPTH + ACTIVE_DEPTH + 1);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_COUNT, S_GRANT} state_t;

	state_t          state_q;
	logic [2:0]      cmd_q;
	logic [SB-1:0]   sid_q;
	logic [31:0]     peer_q;
	logic [QW-1:0]   len_q;
	logic [CW-1:0]   act_q;
	logic [NW-1:0]   cnt_q;
	logic [CFG_W-1:0] base_q;
	logic [CFG_W-1:0] extra_q;

	logic            out_valid_q;
	logic [2:0]      out_status_q;
	logic            out_gv_q;
	logic [7:0]      out_gs_q;
	logic [5:0]      out_pc_q;
	logic [4:0]      out_act_q;
	logic [5:0]      out_len_q;
	logic            out_last_q;

	// cell chain wiring
	logic [SB-1:0]   q_sid  [QUEUE_DEPTH];
	logic [31:0]     q_peer [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] q_match;
	logic [QUEUE_DEPTH:0]   q_drop;
	logic [QW-1:0]   q_acc [QUEUE_DEPTH+1];
	logic [ACTIVE_DEPTH-1:0] a_match;
	logic [ACTIVE_DEPTH:0]   a_free;
	logic [CW-1:0]   a_acc [ACTIVE_DEPTH+1];

	q_ctrl_t         qc;
	a_ctrl_t         ac;
	logic            pop;
	logic [SB-1:0]   a_key;

	logic            out_ok;
	logic            out_load;
	logic [5:0]      slot_sum;
	logic [CW-1:0]   limit;
	logic            q_hit;
	logic            a_hit;
	logic            can_grant;
	logic [CW-1:0]   act_grant;
	logic            grant_last;
	logic [PW-1:0]   pc_sum;

	assign out_ok   = !out_valid_q || rsp.ready;
	assign out_load = out_ok && ((state_q == S_EXEC) || (state_q == S_GRANT));
	assign req.ready = (state_q == S_IDLE);
	assign q_hit    = |q_match;
	assign a_hit    = |a_match;

	// active limit: base plus extra, saturated to the slot count
	assign slot_sum = {1'b0, base_q} + {1'b0, extra_q};
	assign limit    = (LW'(slot_sum) > LW'(ACTIVE_DEPTH)) ? CW'(ACTIVE_DEPTH) : CW'(slot_sum);

	assign can_grant  = (len_q != '0) && (act_q < limit) && (cnt_q < NW'(ACTIVE_DEPTH));
	assign act_grant  = act_q + CW'(!a_hit);
	assign grant_last = !(((cnt_q + 1'b1) < NW'(ACTIVE_DEPTH)) && (len_q != QW'(1))
		&& (act_grant < limit));
	assign pc_sum     = PW'(q_acc[QUEUE_DEPTH]) + PW'(a_acc[ACTIVE_DEPTH]);

	// cell controls for this cycle
	always_comb begin
		qc    = '0;
		ac    = '0;
		pop   = 1'b0;
		a_key = (state_q == S_GRANT) ? q_sid[0] : sid_q;
		if (out_ok) begin
			if (state_q == S_EXEC) begin
				unique case (cmd_q)
					CMD_ENQUEUE: qc.wr = !q_hit && (len_q != QW'(QUEUE_DEPTH));
					CMD_FINISH:  ac.clr = 1'b1;
					CMD_REMOVE: begin
						qc.rm  = 1'b1;
						ac.clr = 1'b1;
					end
					default: ;
				endcase
			end else if (state_q == S_GRANT && can_grant) begin
				pop      = 1'b1;
				ac.alloc = !a_hit;
			end
		end
	end

	assign q_drop[0] = pop;
	assign q_acc[0]  = '0;
	assign a_free[0] = 1'b0;
	assign a_acc[0]  = '0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_q
		logic [SB-1:0] nxt_sid;
		logic [31:0]   nxt_peer;
		if (i + 1 < QUEUE_DEPTH) begin : g_mid
			assign nxt_sid  = q_sid[i+1];
			assign nxt_peer = q_peer[i+1];
		end else begin : g_end
			assign nxt_sid  = '0;
			assign nxt_peer = '0;
		end
		sdq_qcell #(.IDX(i), .QW(QW), .SB(SB), .AW(QW)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctrl(qc), .len(len_q),
			.key_sid(sid_q), .key_peer(peer_q),
			.nxt_sid(nxt_sid), .nxt_peer(nxt_peer),
			.drop_in(q_drop[i]), .drop_out(q_drop[i+1]),
			.acc_in(q_acc[i]), .acc_out(q_acc[i+1]),
			.sid(q_sid[i]), .peer(q_peer[i]), .match(q_match[i])
		);
	end

	for (genvar j = 0; j < ACTIVE_DEPTH; j++) begin : g_a
		sdq_acell #(.SB(SB), .AW(CW)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctrl(ac),
			.key_sid(a_key), .key_peer(peer_q),
			.new_sid(q_sid[0]), .new_peer(q_peer[0]),
			.free_in(a_free[j]), .free_out(a_free[j+1]),
			.acc_in(a_acc[j]), .acc_out(a_acc[j+1]),
			.match(a_match[j])
		);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= CFG_W'(4);
			extra_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE_SLOTS:  base_q  <= cfg_data;
				REG_EXTRA_SLOTS: extra_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// command sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= '0;
			sid_q        <= '0;
			peer_q       <= '0;
			len_q        <= '0;
			act_q        <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= STS_OK;
			out_gv_q     <= 1'b0;
			out_gs_q     <= '0;
			out_pc_q     <= '0;
			out_act_q    <= '0;
			out_len_q    <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (req.valid) begin
						cmd_q  <= req.command;
						sid_q  <= SB'(req.session_id);
						peer_q <= req.peer_id;
						priority if (req.command == CMD_COUNT) begin
							state_q <= S_COUNT;
						end else if (req.command == CMD_TICK) begin
							state_q <= S_GRANT;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_COUNT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == NW'(CMAX)) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_ok) begin
						logic [2:0]    sts;
						logic [QW-1:0] len_n;
						logic [CW-1:0] act_n;
						sts   = STS_OK;
						len_n = len_q;
						act_n = act_q;
						unique case (cmd_q)
							CMD_ENQUEUE: begin
								if (q_hit) begin
									sts = STS_DUPLICATE;
								end else if (len_q == QW'(QUEUE_DEPTH)) begin
									sts = STS_FULL;
								end else begin
									len_n = len_q + 1'b1;
								end
							end
							CMD_FINISH: begin
								if (a_hit) begin
									act_n = act_q - 1'b1;
								end else begin
									sts = STS_NOT_ACTIVE;
								end
							end
							CMD_REMOVE: begin
								if (q_hit) len_n = len_q - 1'b1;
								if (a_hit) act_n = act_q - 1'b1;
								if (!q_hit && !a_hit) sts = STS_NOT_FOUND;
							end
							default: ;
						endcase
						len_q        <= len_n;
						act_q        <= act_n;
						out_status_q <= sts;
						out_gv_q     <= 1'b0;
						out_gs_q     <= '0;
						out_pc_q     <= (cmd_q == CMD_COUNT) ? 6'(pc_sum) : 6'd0;
						out_act_q    <= 5'(act_n);
						out_len_q    <= 6'(len_n);
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_GRANT: begin
					if (out_ok) begin
						out_status_q <= STS_OK;
						out_pc_q     <= '0;
						if (can_grant) begin
							len_q      <= len_q - 1'b1;
							act_q      <= act_grant;
							cnt_q      <= cnt_q + 1'b1;
							out_gv_q   <= 1'b1;
							out_gs_q   <= 8'(q_sid[0]);
							out_act_q  <= 5'(act_grant);
							out_len_q  <= 6'(len_q - 1'b1);
							out_last_q <= grant_last;
							if (grant_last) state_q <= S_IDLE;
						end else begin
							out_gv_q   <= 1'b0;
							out_gs_q   <= '0;
							out_act_q  <= 5'(act_q);
							out_len_q  <= 6'(len_q);
							out_last_q <= 1'b1;
							state_q    <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_status_q;
	assign rsp.granted_valid   = out_gv_q;
	assign rsp.granted_session = out_gs_q;
	assign rsp.peer_count      = out_pc_q;
	assign rsp.active_count    = out_act_q;
	assign rsp.queued_count    = out_len_q;
	assign rsp.last            = out_last_q;

endmodule
